### design/btkb_pkg.sv
// Shared types and constants for the keyboard message bridge.
// Used by the front end, the command queue, the back end, the top level and the checker.
package btkb_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 32;
  localparam int unsigned REPORT_BYTES   = 8;
  // Only the first thirteen line bytes are ever read: the longest status string.
  localparam int unsigned LINE_HEAD      = 13;
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned IDX_W          = $clog2(REPORT_BYTES);

  localparam logic [7:0] CR_BYTE     = 8'h0D;
  localparam logic [7:0] KEY_END     = 8'hEF;
  localparam logic [7:0] LED_ASK     = 8'hFE;
  localparam logic [7:0] LED_ON      = 8'h0F;
  localparam logic [7:0] STAT_KEY    = 8'h01;
  localparam logic [7:0] STAT_CONN   = 8'h02;
  localparam logic [7:0] STAT_DISC   = 8'h03;
  localparam logic [7:0] STAT_OTHER  = 8'h04;
  localparam logic       KIND_UART   = 1'b0;
  localparam logic       KIND_LED    = 1'b1;
  localparam logic       DEST_UART   = 1'b0;
  localparam logic       DEST_HOST   = 1'b1;

  typedef logic [0:LINE_HEAD-1][7:0] head_t;

  localparam head_t TXT_READY = {"+READY", 56'h0};
  localparam head_t TXT_CONN  = {"+CONNECTED", 24'h0};
  localparam head_t TXT_DISC  = {"+DISCONNECTED"};
  localparam head_t TXT_ADV   = {"+ADVERTISING", 8'h0};
  localparam logic [3:0] LEN_READY = 4'd6;
  localparam logic [3:0] LEN_CONN  = 4'd10;
  localparam logic [3:0] LEN_DISC  = 4'd13;
  localparam logic [3:0] LEN_ADV   = 4'd12;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } out_item_t;

  typedef enum logic {
    OP_PAIR   = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef logic [REPORT_BYTES-1:0][7:0] report_t;

  // A pair carries its byte in slot 0 and the carriage return in slot 1.
  typedef struct packed {
    op_e     op;
    report_t bytes;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### design/btkb_front.sv
// Front end: accepts requests, keeps the line head, cursor, report and LED state,
// and turns each request into at most one command. Depends on btkb_pkg.
module btkb_front #(
  parameter int unsigned LINE_DEPTH = btkb_pkg::LINE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  btkb_pkg::in_item_t in_item_i,
  input  btkb_pkg::q_status_t q_status_i,
  output logic              push_o,
  output btkb_pkg::cmd_t    cmd_o
);
  import btkb_pkg::*;

  localparam int unsigned CUR_W = $clog2(LINE_DEPTH);

  head_t             line_q, line_d;
  logic [CUR_W-1:0]  cursor_q, cursor_d;
  report_t           report_q, report_d;
  logic [7:0]        led_q, led_d;
  logic              accept;
  logic              send_report, send_pair;
  logic [7:0]        pair_byte;

  function automatic logic starts_with(input head_t line, input head_t pat,
                                       input logic [3:0] n);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < LINE_HEAD; i++) begin
      if ((4'(i) < n) && (line[i] != pat[i])) hit = 1'b0;
    end
    return hit;
  endfunction

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    line_d      = line_q;
    cursor_d    = cursor_q;
    report_d    = report_q;
    led_d       = led_q;
    send_report = 1'b0;
    send_pair   = 1'b0;
    pair_byte   = led_q;
    if (accept) begin
      if (in_item_i.kind == KIND_LED) begin
        if (in_item_i.value != led_q) begin
          led_d     = in_item_i.value;
          pair_byte = in_item_i.value;
          send_pair = 1'b1;
        end
      end else begin
        // Bytes past the line head are never read back, so they are not kept.
        for (int i = 0; i < LINE_HEAD; i++) begin
          if (cursor_q == CUR_W'(i)) line_d[i] = in_item_i.value;
        end
        priority if (in_item_i.value == CR_BYTE) begin
          cursor_d = '0;
          priority if (cursor_q < CUR_W'(8)) begin
            if (!starts_with(line_d, TXT_READY, LEN_READY)) begin
              report_d[1] = STAT_OTHER;
              send_report = 1'b1;
            end
          end else if (starts_with(line_d, TXT_CONN, LEN_CONN)) begin
            report_d[1] = STAT_CONN;
            led_d       = LED_ON;
            send_report = 1'b1;
          end else if (starts_with(line_d, TXT_DISC, LEN_DISC)) begin
            report_d[1] = STAT_DISC;
            send_report = 1'b1;
          end else begin
            if (!starts_with(line_d, TXT_ADV, LEN_ADV)) begin
              report_d[1] = STAT_OTHER;
              send_report = 1'b1;
            end
          end
        end else if (in_item_i.value == KEY_END) begin
          cursor_d    = '0;
          report_d[0] = line_d[0];
          report_d[1] = STAT_KEY;
          for (int i = 2; i < REPORT_BYTES; i++) begin
            if (CUR_W'(i) <= cursor_q) report_d[i] = line_d[i-1];
          end
          send_report = 1'b1;
        end else if (in_item_i.value == LED_ASK) begin
          cursor_d  = '0;
          send_pair = 1'b1;
        end else begin
          if (cursor_q < CUR_W'(LINE_DEPTH - 1)) cursor_d = cursor_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    cmd_o = '0;
    if (send_report) begin
      cmd_o.op    = OP_REPORT;
      cmd_o.bytes = report_d;
    end else begin
      cmd_o.op       = OP_PAIR;
      cmd_o.bytes[0] = pair_byte;
      cmd_o.bytes[1] = CR_BYTE;
    end
  end

  assign push_o = send_report || send_pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= '0;
      cursor_q <= '0;
      report_q <= '0;
      led_q    <= '0;
    end else begin
      line_q   <= line_d;
      cursor_q <= cursor_d;
      report_q <= report_d;
      led_q    <= led_d;
    end
  end

endmodule

### design/btkb_fifo.sv
// Short command queue between the front end and the back end.
// Depends on btkb_pkg for the command type and depth.
module btkb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  btkb_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output btkb_pkg::cmd_t      cmd_o,
  output btkb_pkg::q_status_t status_o
);
  import btkb_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign cmd_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### design/btkb_back.sv
// Back end: takes commands from the queue and sends their bytes one per cycle
// while the output is not stalled, from registered state. Depends on btkb_pkg.
module btkb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btkb_pkg::cmd_t      cmd_i,
  input  btkb_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output btkb_pkg::out_item_t out_item_o
);
  import btkb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             is_last, fire;

  assign is_last = (cur_q.op == OP_REPORT) ? (idx_q == IDX_W'(REPORT_BYTES - 1))
                                           : (idx_q == IDX_W'(1));
  assign out_valid_o = (state_q == ST_SEND);
  assign fire        = out_valid_o && !out_stall_i;

  assign out_item_o.dest = (cur_q.op == OP_REPORT) ? DEST_HOST : DEST_UART;
  assign out_item_o.data = cur_q.bytes[idx_q];
  assign out_item_o.last = is_last;

  // The next command is loaded in the cycle the final byte of the current one leaves.
  assign pop_o = !q_status_i.empty && ((state_q == ST_IDLE) || (fire && is_last));

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    if (pop_o) begin
      state_d = ST_SEND;
      cur_d   = cmd_i;
      idx_d   = '0;
    end else if (fire) begin
      if (is_last) state_d = ST_IDLE;
      else         idx_d   = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

### design/bt_keyboard_message_bridge_top.sv
// Keyboard message bridge: one request per cycle enters the front end while the queue has room.
// Each result passes through the queue and then the back end's command register; a report has
// eight bytes and an LED echo two, sent one byte per cycle while the output is not stalled.
// The output does not block the input until two commands wait in the queue.
// Reset (asynchronous, active low) clears the line, cursor, report, LED state and queue at once.
module bt_keyboard_message_bridge_top #(
  parameter int unsigned LINE_DEPTH = btkb_pkg::LINE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  btkb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output btkb_pkg::out_item_t out_data_o
);
  import btkb_pkg::*;

  logic      push, pop;
  cmd_t      cmd_in, cmd_out;
  q_status_t q_status;

  btkb_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  btkb_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_out),
    .status_o (q_status)
  );

  btkb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_data_o)
  );

endmodule

### design/btkb_checker.sv
// Port-level checks for the keyboard message bridge, bound to the top level.
// Depends on btkb_pkg and bt_keyboard_message_bridge_top.
module btkb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input btkb_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input btkb_pkg::out_item_t out_data_o
);
  import btkb_pkg::*;

  // A stalled request stays offered unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed or dropped");

  // A stalled result stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A run is never broken: after a byte that is not the last, the next one follows at once.
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last
    |=> out_valid_o && (out_data_o.dest == $past(out_data_o.dest)))
    else $error("run broken or destination changed mid-run");

  // Every run to the module ends in a carriage return.
  a_uart_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.dest == DEST_UART) && out_data_o.last
    |-> out_data_o.data == CR_BYTE)
    else $error("module run does not end in carriage return");

  // Nothing is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

endmodule

bind bt_keyboard_message_bridge_top btkb_checker u_btkb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
